// ----- sv/ffa_pkg.sv -----
// Package for the forest fire automaton step unit: sizes, codes, cell type,
// controller state and command/status types, and the cell update function.
// Depends on nothing; every other file of the block uses it.
package ffa_pkg;

	// Grid and value sizes.
	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;
	localparam int VALUE_BITS = 8;

	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
	localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
	localparam int CELLS     = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int LB_DEPTH  = 3 * MAX_COLS;
	localparam int LB_AW     = $clog2(LB_DEPTH);
	localparam int CNT_W     = 4;

	// Field widths of the transactions.
	localparam int OP_W       = 2;
	localparam int POS_W      = 6;
	localparam int STATE_W    = 2;
	localparam int VAL_W      = 8;
	localparam int DIM_W      = 7;
	localparam int KIND_W     = 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 24;
	localparam int M_PAD_W    = M_TDATA_W - STATE_W - 2 * VAL_W;

	localparam logic [VAL_W-1:0] VAL_MASK = VAL_W'((1 << VALUE_BITS) - 1);

	// Operation codes.
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

	// Cell state codes.
	localparam logic [STATE_W-1:0] CELL_GROW = 2'd0;
	localparam logic [STATE_W-1:0] CELL_BURN = 2'd1;
	localparam logic [STATE_W-1:0] CELL_DEAD = 2'd2;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_READ = 1'b0;
	localparam logic [KIND_W-1:0] KIND_STEP = 1'b1;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REGROW_HEALTH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REGROW_ARMOR  = 2'd3;

	// Reset values.
	localparam logic [DIM_W-1:0] DIM_RESET    = 7'd64;
	localparam logic [VAL_W-1:0] RESET_HEALTH = 8'd10;
	localparam logic [VAL_W-1:0] RESET_ARMOR  = 8'd5;

	typedef struct packed {
		logic [VAL_W-1:0]   armor;
		logic [VAL_W-1:0]   health;
		logic [STATE_W-1:0] state;
	} cell_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic clear_wr;
		logic scan_issue;
		logic out_rd;
		logic out_done;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic scan_last;
		logic out_valid;
	} ctl_status_t;

	// Linear cell store address of a row and column.
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
	endfunction

	// Line buffer address of a slot and column.
	function automatic logic [LB_AW-1:0] lb_addr(input logic [1:0] slot,
			input logic [COL_W-1:0] c);
		return LB_AW'(slot) * LB_AW'(MAX_COLS) + LB_AW'(c);
	endfunction

	// One generation of a single cell, given its burning neighbour count.
	function automatic cell_t next_cell(input cell_t c, input logic [CNT_W-1:0] n,
			input logic [VAL_W-1:0] rh, input logic [VAL_W-1:0] ra);
		cell_t            r;
		logic [VAL_W-1:0] nx;
		r  = c;
		nx = VAL_W'(n);
		if (c.state == CELL_GROW) begin
			r.armor = (c.armor > nx) ? c.armor - nx : '0;
		end
		if (c.state == CELL_BURN) begin
			r.health = (c.health > nx) ? c.health - nx : '0;
		end
		if (c.state == CELL_DEAD) begin
			r.state  = CELL_GROW;
			r.armor  = ra;
			r.health = rh;
		end
		if (r.armor == '0 && r.health != '0) begin
			r.state = CELL_BURN;
		end
		if (r.health == '0) begin
			r.state = CELL_DEAD;
		end
		return r;
	endfunction

endpackage

// ----- sv/ffa_ctrl.sv -----
// Controller of the forest fire automaton step unit: sequences the clearing
// pass, single cell transactions and the generation scan.
// Depends on ffa_pkg for the state, command and status types.
module ffa_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [ffa_pkg::OP_W-1:0]  op,
	input  logic                      m_tready,
	input  ffa_pkg::ctl_status_t      status,
	output ffa_pkg::ctl_cmd_t         cmd
);

	ffa_pkg::ctl_state_t state_q, state_nx;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffa_pkg::S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nx = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ffa_pkg::S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_last) begin
					state_nx = ffa_pkg::S_IDLE;
				end
			end
			ffa_pkg::S_IDLE: begin
				// A new transaction is taken once the result slot is free or freeing.
				s_tready   = !status.out_valid || m_tready;
				cmd.accept = s_tvalid && s_tready;
				if (cmd.accept) begin
					if (op == ffa_pkg::OP_READ) begin
						state_nx = ffa_pkg::S_READ;
					end else if (op == ffa_pkg::OP_STEP) begin
						state_nx = ffa_pkg::S_SCAN;
					end
				end
			end
			ffa_pkg::S_READ: begin
				cmd.out_rd = 1'b1;
				state_nx   = ffa_pkg::S_IDLE;
			end
			ffa_pkg::S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (status.scan_last) begin
					state_nx = ffa_pkg::S_DRAIN;
				end
			end
			ffa_pkg::S_DRAIN: begin
				state_nx = ffa_pkg::S_DONE;
			end
			ffa_pkg::S_DONE: begin
				if (!status.out_valid || m_tready) begin
					cmd.out_done = 1'b1;
					state_nx     = ffa_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = ffa_pkg::S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	// An accepted read loads the result register in the very next cycle.
	a_read_next: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && op == ffa_pkg::OP_READ) |=> cmd.out_rd)
		else $error("read result not loaded after accepted read");

	// The last scan position is followed by the drain state and then completion.
	a_scan_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_issue && status.scan_last) |=> ##1 (state_q == ffa_pkg::S_DONE))
		else $error("scan did not finish through the drain cycle");
`endif

endmodule

// ----- sv/ffa_datapath.sv -----
// Datapath of the forest fire automaton step unit: configuration registers,
// cell store, old state line buffer, 3x3 neighbour window and result register.
// Depends on ffa_pkg for sizes, codes, types and the cell update function.
module ffa_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ffa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ffa_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [ffa_pkg::OP_W-1:0]        in_op,
	input  logic [ffa_pkg::POS_W-1:0]       in_row,
	input  logic [ffa_pkg::POS_W-1:0]       in_col,
	input  ffa_pkg::cell_t                  in_cell,
	input  logic                            m_tready,
	input  ffa_pkg::ctl_cmd_t               cmd,
	output ffa_pkg::ctl_status_t            status,
	output logic [ffa_pkg::KIND_W-1:0]      out_kind,
	output ffa_pkg::cell_t                  out_cell
);

	localparam int ROW_W     = ffa_pkg::ROW_W;
	localparam int COL_W     = ffa_pkg::COL_W;
	localparam int ROW_CNT_W = ffa_pkg::ROW_CNT_W;
	localparam int COL_CNT_W = ffa_pkg::COL_CNT_W;
	localparam int ADDR_W    = ffa_pkg::ADDR_W;
	localparam int LB_AW     = ffa_pkg::LB_AW;
	localparam int CNT_W     = ffa_pkg::CNT_W;
	localparam int VAL_W     = ffa_pkg::VAL_W;
	localparam int DIM_W     = ffa_pkg::DIM_W;
	localparam int STATE_W   = ffa_pkg::STATE_W;

	// Configuration registers.
	logic [DIM_W-1:0] grid_width_q, grid_height_q;
	logic [VAL_W-1:0] regrow_health_q, regrow_armor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q    <= ffa_pkg::DIM_RESET;
			grid_height_q   <= ffa_pkg::DIM_RESET;
			regrow_health_q <= ffa_pkg::RESET_HEALTH;
			regrow_armor_q  <= ffa_pkg::RESET_ARMOR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ffa_pkg::CFG_GRID_WIDTH:    grid_width_q    <= cfg_data[DIM_W-1:0];
				ffa_pkg::CFG_GRID_HEIGHT:   grid_height_q   <= cfg_data[DIM_W-1:0];
				ffa_pkg::CFG_REGROW_HEALTH: regrow_health_q <= cfg_data[VAL_W-1:0];
				ffa_pkg::CFG_REGROW_ARMOR:  regrow_armor_q  <= cfg_data[VAL_W-1:0];
			endcase
		end
	end

	// Used grid size, saturated at the store size.
	logic [ROW_CNT_W-1:0] h_used;
	logic [COL_CNT_W-1:0] w_used;
	logic                 on_grid;

	assign h_used = (int'(grid_height_q) > ffa_pkg::MAX_ROWS) ?
		ROW_CNT_W'(ffa_pkg::MAX_ROWS) : ROW_CNT_W'(grid_height_q);
	assign w_used = (int'(grid_width_q) > ffa_pkg::MAX_COLS) ?
		COL_CNT_W'(ffa_pkg::MAX_COLS) : COL_CNT_W'(grid_width_q);
	assign on_grid = (int'(in_row) < int'(h_used)) && (int'(in_col) < int'(w_used));

	// Clearing pass address counter.
	logic [ADDR_W-1:0] clr_cnt_q;

	assign status.clear_last = (clr_cnt_q == ADDR_W'(ffa_pkg::CELLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_cnt_q <= status.clear_last ? '0 : clr_cnt_q + ADDR_W'(1);
		end
	end

	// Scan position: rn_q is the look-ahead row, cr_q the look-ahead column.
	// The centre cell being updated sits one row above and one column left.
	logic [ROW_CNT_W-1:0] rn_q, rn_m1;
	logic [COL_CNT_W-1:0] cr_q, cr_m1;
	logic [1:0]           slot_nx_q, slot_cur_q, slot_prv_q;
	logic                 row_end, step_start;

	assign row_end          = (cr_q == w_used);
	assign status.scan_last = row_end && (rn_q == h_used);
	assign step_start       = cmd.accept && (in_op == ffa_pkg::OP_STEP);
	assign rn_m1            = rn_q - ROW_CNT_W'(1);
	assign cr_m1            = cr_q - COL_CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rn_q       <= '0;
			cr_q       <= '0;
			slot_nx_q  <= 2'd0;
			slot_cur_q <= 2'd1;
			slot_prv_q <= 2'd2;
		end else if (step_start) begin
			rn_q       <= '0;
			cr_q       <= '0;
			slot_nx_q  <= 2'd0;
			slot_cur_q <= 2'd1;
			slot_prv_q <= 2'd2;
		end else if (cmd.scan_issue) begin
			if (row_end) begin
				cr_q       <= '0;
				rn_q       <= rn_q + ROW_CNT_W'(1);
				slot_prv_q <= slot_cur_q;
				slot_cur_q <= slot_nx_q;
				slot_nx_q  <= slot_prv_q;
			end else begin
				cr_q <= cr_q + COL_CNT_W'(1);
			end
		end
	end

	// Stage one of the scan: look-ahead and centre reads are issued.
	logic              col_ok;
	logic [ADDR_W-1:0] la_addr, rdb_addr;
	logic [COL_W-1:0]  la_col;

	assign col_ok  = (cr_q < w_used);
	assign la_col  = cr_q[COL_W-1:0];
	assign la_addr = ffa_pkg::cell_addr(rn_q[ROW_W-1:0], la_col);

	assign rdb_addr = cmd.scan_issue ?
		ffa_pkg::cell_addr(rn_m1[ROW_W-1:0], cr_m1[COL_W-1:0]) :
		ffa_pkg::cell_addr(ROW_W'(in_row), COL_W'(in_col));

	// Stage two registers.
	logic              v_s1, pre_s1, cen_s1, top_ok_s1, mid_ok_s1, bot_ok_s1;
	logic [LB_AW-1:0]  lb_waddr_s1;
	logic [ADDR_W-1:0] cen_addr_s1;
	logic              on_grid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_issue;
		end
	end

	always_ff @(posedge clk) begin
		pre_s1      <= (cr_q == '0);
		cen_s1      <= (rn_q != '0) && (cr_q != '0);
		top_ok_s1   <= col_ok && (rn_q >= ROW_CNT_W'(2));
		mid_ok_s1   <= col_ok && (rn_q != '0);
		bot_ok_s1   <= col_ok && (rn_q < h_used);
		lb_waddr_s1 <= ffa_pkg::lb_addr(slot_nx_q, la_col);
		cen_addr_s1 <= rdb_addr;
		if (cmd.accept) begin
			on_grid_q <= on_grid;
		end
	end

	// Cell store: one write port, two registered read ports.
	ffa_pkg::cell_t    cell_mem [ffa_pkg::CELLS];
	ffa_pkg::cell_t    rda_q, rdb_q, mem_wd, new_cell;
	logic              mem_we, acc_wr, cen_wr;
	logic [ADDR_W-1:0] mem_wa;

	assign acc_wr = cmd.accept && (in_op == ffa_pkg::OP_WRITE) && on_grid;
	assign cen_wr = v_s1 && cen_s1;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_cnt_q;
		mem_wd = '{armor: ffa_pkg::RESET_ARMOR & ffa_pkg::VAL_MASK,
			health: ffa_pkg::RESET_HEALTH & ffa_pkg::VAL_MASK, state: ffa_pkg::CELL_GROW};
		priority if (cmd.clear_wr) begin
			mem_we = 1'b1;
		end else if (cen_wr) begin
			mem_we = 1'b1;
			mem_wa = cen_addr_s1;
			mem_wd = new_cell;
		end else if (acc_wr) begin
			mem_we = 1'b1;
			mem_wa = ffa_pkg::cell_addr(ROW_W'(in_row), COL_W'(in_col));
			mem_wd = '{armor: in_cell.armor & ffa_pkg::VAL_MASK,
				health: in_cell.health & ffa_pkg::VAL_MASK, state: in_cell.state};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem[mem_wa] <= mem_wd;
		end
		rda_q <= cell_mem[la_addr];
		rdb_q <= cell_mem[rdb_addr];
	end

	// Old state line buffer: three rows, written from the look-ahead row.
	logic [STATE_W-1:0] lb_mem [ffa_pkg::LB_DEPTH];
	logic [STATE_W-1:0] lba_q, lbb_q;

	always_ff @(posedge clk) begin
		if (v_s1 && bot_ok_s1) begin
			lb_mem[lb_waddr_s1] <= rda_q.state;
		end
		lba_q <= lb_mem[ffa_pkg::lb_addr(slot_prv_q, la_col)];
		lbb_q <= lb_mem[ffa_pkg::lb_addr(slot_cur_q, la_col)];
	end

	// Neighbour window: bit 0 top, bit 1 middle, bit 2 bottom row.
	logic [2:0]       win_l_q, win_m_q, win_n;
	logic [CNT_W-1:0] burn_cnt;

	assign win_n[0] = top_ok_s1 && (lba_q == ffa_pkg::CELL_BURN);
	assign win_n[1] = mid_ok_s1 && (lbb_q == ffa_pkg::CELL_BURN);
	assign win_n[2] = bot_ok_s1 && (rda_q.state == ffa_pkg::CELL_BURN);

	assign burn_cnt = CNT_W'(win_l_q[0]) + CNT_W'(win_l_q[1]) + CNT_W'(win_l_q[2])
		+ CNT_W'(win_m_q[0]) + CNT_W'(win_m_q[2])
		+ CNT_W'(win_n[0]) + CNT_W'(win_n[1]) + CNT_W'(win_n[2]);

	assign new_cell = ffa_pkg::next_cell(rdb_q, burn_cnt,
		regrow_health_q & ffa_pkg::VAL_MASK, regrow_armor_q & ffa_pkg::VAL_MASK);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			win_l_q <= pre_s1 ? 3'b000 : win_m_q;
			win_m_q <= win_n;
		end
	end

	// Result register.
	logic out_valid_q;

	assign status.out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_rd || cmd.out_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_rd) begin
			out_kind <= ffa_pkg::KIND_READ;
			out_cell <= on_grid_q ? rdb_q : '0;
		end else if (cmd.out_done) begin
			out_kind <= ffa_pkg::KIND_STEP;
			out_cell <= '0;
		end
	end

`ifndef SYNTHESIS
	// The cell store write port has one source at a time.
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_wr, cen_wr, acc_wr}))
		else $error("cell store write port driven by more than one source");

	// A result is never loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_rd || cmd.out_done) |-> (!out_valid_q || m_tready))
		else $error("result register overwritten before transaction");
`endif

endmodule

// ----- sv/forest_fire_automaton_step_unit.sv -----
// Top level of the forest fire automaton step unit: unpacks the streams and
// joins the controller and datapath. Depends on ffa_pkg, ffa_ctrl, ffa_datapath.
//
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid / s_tready  s_tuser operation, s_tdata cell access
// m_       out        m_tvalid / m_tready  m_tuser result kind, m_tdata cell
// cfg_     in         cfg_we               cfg_index, cfg_data
//
// After reset a clearing pass writes every cell of the store, one per cycle;
// no transaction is taken during it (configuration writes are).
// A write is stored on acceptance; a read passes the store read register and
// the result register. A step scans look-ahead positions (h+1)*(w+1) at one
// cell per cycle through the cell store ports, then drains and completes.
// A new transaction is taken only while the result register is free or freeing.
module forest_fire_automaton_step_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// Bits from lowest: row[5:0], column[11:6], new_state[13:12],
	// new_health[21:14], new_armor[29:22], zero[31:30].
	input  logic [ffa_pkg::S_TDATA_W-1:0]     s_tdata,
	// Bits from lowest: operation[1:0].
	input  logic [ffa_pkg::OP_W-1:0]          s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// Bits from lowest: cell_state[1:0], cell_health[9:2], cell_armor[17:10],
	// zero[23:18].
	output logic [ffa_pkg::M_TDATA_W-1:0]     m_tdata,
	// Bits from lowest: result_kind[0].
	output logic [ffa_pkg::KIND_W-1:0]        m_tuser,
	input  logic                              cfg_we,
	input  logic [ffa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ffa_pkg::CFG_DATA_W-1:0]    cfg_data
);

	ffa_pkg::ctl_cmd_t    cmd;
	ffa_pkg::ctl_status_t status;
	ffa_pkg::cell_t       in_cell, out_cell;
	logic [ffa_pkg::POS_W-1:0] in_row, in_col;

	// Input field unpacking.
	assign in_row         = s_tdata[5:0];
	assign in_col         = s_tdata[11:6];
	assign in_cell.state  = s_tdata[13:12];
	assign in_cell.health = s_tdata[21:14];
	assign in_cell.armor  = s_tdata[29:22];

	// Output field packing.
	assign m_tvalid = status.out_valid;
	assign m_tdata  = {{ffa_pkg::M_PAD_W{1'b0}}, out_cell.armor, out_cell.health,
		out_cell.state};

	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ffa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_op     (s_tuser),
		.in_row    (in_row),
		.in_col    (in_col),
		.in_cell   (in_cell),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.status    (status),
		.out_kind  (m_tuser),
		.out_cell  (out_cell)
	);

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the forest fire automaton step unit: a directed
// table of cell accesses and steps, then random phases over several grid sizes.
// Depends on ffa_pkg and forest_fire_automaton_step_unit.
module tb;
	import ffa_pkg::*;

	// Codes the package leaves unnamed.
	localparam logic [OP_W-1:0]    OP_UNUSED  = 2'd3;
	localparam logic [STATE_W-1:0] CELL_SPARE = 2'd3;

	localparam int LIMIT_CYCLES  = 600000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int DIR_ROWS      = 26;
	localparam int DIR_SMALL     = 17;
	localparam int DIR_EMPTY     = 24;
	localparam int PHASES        = 8;

	// One result transaction as the receiver sees it.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [STATE_W-1:0] state;
		logic [VAL_W-1:0]   health;
		logic [VAL_W-1:0]   armor;
	} outcome_t;

	// One input transaction, with an optional result typed in by hand.
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [POS_W-1:0]   row;
		logic [POS_W-1:0]   col;
		logic [STATE_W-1:0] st;
		logic [VAL_W-1:0]   hp;
		logic [VAL_W-1:0]   ar;
		logic               typed;
		outcome_t           want;
	} probe_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic [OP_W-1:0]       s_tuser   = OP_WRITE;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [KIND_W-1:0]     m_tuser;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_GRID_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Idling control shared by the sender and the receiver.
	logic quiet      = 1'b0;
	logic hold_req   = 1'b0;
	logic hold_taken = 1'b0;
	int   hold_left  = 0;

	int cycle_count = 0;
	int fail_count  = 0;

	// Predicted grid, its settings and the results still owed by the block.
	cell_t              grid_mem   [MAX_ROWS][MAX_COLS];
	logic [STATE_W-1:0] old_states [MAX_ROWS][MAX_COLS];
	logic [DIM_W-1:0]   cols_cfg;
	logic [DIM_W-1:0]   rows_cfg;
	logic [VAL_W-1:0]   regrow_hp;
	logic [VAL_W-1:0]   regrow_ar;
	outcome_t           due_outcomes [$];
	probe_t             dir_rows [DIR_ROWS];

	forest_fire_automaton_step_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog on the length of the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("** forest_fire_automaton_step_unit: FAILED **");
			$finish;
		end
	end

	function automatic int used_rows();
		return (rows_cfg > DIM_W'(MAX_ROWS)) ? MAX_ROWS : int'(rows_cfg);
	endfunction

	function automatic int used_cols();
		return (cols_cfg > DIM_W'(MAX_COLS)) ? MAX_COLS : int'(cols_cfg);
	endfunction

	function automatic probe_t plain_row(input logic [OP_W-1:0] op, input int r, input int c,
			input logic [STATE_W-1:0] st, input int hp, input int ar);
		probe_t p;
		p       = '0;
		p.op    = op;
		p.row   = POS_W'(r);
		p.col   = POS_W'(c);
		p.st    = st;
		p.hp    = VAL_W'(hp);
		p.ar    = VAL_W'(ar);
		return p;
	endfunction

	function automatic probe_t known_row(input logic [OP_W-1:0] op, input int r, input int c,
			input logic [KIND_W-1:0] kind, input logic [STATE_W-1:0] st, input int hp,
			input int ar);
		probe_t p;
		p             = '0;
		p.op          = op;
		p.row         = POS_W'(r);
		p.col         = POS_W'(c);
		p.typed       = 1'b1;
		p.want.kind   = kind;
		p.want.state  = st;
		p.want.health = VAL_W'(hp);
		p.want.armor  = VAL_W'(ar);
		return p;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("[cycle %0d] mismatch: %s", cycle_count, msg);
	endtask

	// One generation: every used cell sees the burning neighbours of the old grid.
	task automatic burn_generation();
		int    h;
		int    w;
		int    n;
		cell_t cur;
		h = used_rows();
		w = used_cols();
		for (int ri = 0; ri < h; ri++) begin
			for (int ci = 0; ci < w; ci++) begin
				old_states[ri][ci] = grid_mem[ri][ci].state;
			end
		end
		for (int ri = 0; ri < h; ri++) begin
			for (int ci = 0; ci < w; ci++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						if ((dr != 0 || dc != 0) && ri + dr >= 0 && ri + dr < h &&
								ci + dc >= 0 && ci + dc < w &&
								old_states[ri + dr][ci + dc] == CELL_BURN) begin
							n++;
						end
					end
				end
				cur = grid_mem[ri][ci];
				if (cur.state == CELL_GROW) begin
					cur.armor = (cur.armor > VAL_W'(n)) ? cur.armor - VAL_W'(n) : '0;
				end
				if (cur.state == CELL_BURN) begin
					cur.health = (cur.health > VAL_W'(n)) ? cur.health - VAL_W'(n) : '0;
				end
				if (cur.state == CELL_DEAD) begin
					cur.state  = CELL_GROW;
					cur.armor  = regrow_ar;
					cur.health = regrow_hp;
				end
				if (cur.armor == '0 && cur.health != '0) begin
					cur.state = CELL_BURN;
				end
				if (cur.health == '0) begin
					cur.state = CELL_DEAD;
				end
				grid_mem[ri][ci] = cur;
			end
		end
	endtask

	// Applies one accepted transaction to the predicted grid.
	task automatic apply_operation(input probe_t item, output bit produces,
			output outcome_t res);
		bit on_grid;
		on_grid  = int'(item.row) < used_rows() && int'(item.col) < used_cols();
		produces = 1'b0;
		res      = '0;
		case (item.op)
			OP_WRITE: begin
				if (on_grid) begin
					grid_mem[item.row][item.col].state  = item.st;
					grid_mem[item.row][item.col].health = item.hp;
					grid_mem[item.row][item.col].armor  = item.ar;
				end
			end
			OP_READ: begin
				produces = 1'b1;
				res.kind = KIND_READ;
				if (on_grid) begin
					res.state  = grid_mem[item.row][item.col].state;
					res.health = grid_mem[item.row][item.col].health;
					res.armor  = grid_mem[item.row][item.col].armor;
				end
			end
			OP_STEP: begin
				burn_generation();
				produces = 1'b1;
				res.kind = KIND_STEP;
			end
			default: begin
			end
		endcase
	endtask

	// Offers one transaction after a random idle spell and records its result.
	task automatic offer_item(input probe_t item);
		bit       produces;
		outcome_t res;
		while (!quiet && $urandom_range(0, 99) < 17) begin
			s_tvalid <= 1'b0;
			s_tdata  <= S_TDATA_W'($urandom);
			s_tuser  <= OP_W'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= item.op;
		s_tdata  <= S_TDATA_W'({item.ar, item.hp, item.st, item.col, item.row});
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		apply_operation(item, produces, res);
		if (item.typed) begin
			res = item.want;
		end
		if (produces) begin
			due_outcomes = {due_outcomes, res};
		end
	endtask

	// Stops offering and waits until the block has returned everything owed.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (due_outcomes.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_GRID_WIDTH:    cols_cfg  = val[DIM_W-1:0];
			CFG_GRID_HEIGHT:   rows_cfg  = val[DIM_W-1:0];
			CFG_REGROW_HEALTH: regrow_hp = val;
			CFG_REGROW_ARMOR:  regrow_ar = val;
			default: begin
			end
		endcase
	endtask

	task automatic program_grid(input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] rows,
			input logic [CFG_DATA_W-1:0] hp, input logic [CFG_DATA_W-1:0] ar);
		write_reg(CFG_GRID_WIDTH, cols);
		write_reg(CFG_GRID_HEIGHT, rows);
		write_reg(CFG_REGROW_HEALTH, hp);
		write_reg(CFG_REGROW_ARMOR, ar);
		cfg_we <= 1'b0;
	endtask

	// Random transactions, mostly on the used grid with small values so that
	// fires spread and burn out; only effective transactions are counted.
	task automatic run_phase(input int n_items, input int step_pct);
		probe_t item;
		int     done;
		int     h;
		int     w;
		int     roll;
		bit     on_grid;
		done = 0;
		while (done < n_items) begin
			h    = used_rows();
			w    = used_cols();
			item = '0;
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				item.op = OP_WRITE;
			end else if (roll < 95 - step_pct) begin
				item.op = OP_READ;
			end else if (roll < 95) begin
				item.op = OP_STEP;
			end else begin
				item.op = OP_UNUSED;
			end
			if (h > 0 && w > 0 && $urandom_range(0, 99) < 85) begin
				item.row = POS_W'($urandom_range(0, h - 1));
				item.col = POS_W'($urandom_range(0, w - 1));
			end else begin
				item.row = POS_W'($urandom);
				item.col = POS_W'($urandom);
			end
			item.st = ($urandom_range(0, 7) == 0) ? CELL_SPARE : STATE_W'($urandom_range(0, 2));
			item.hp = ($urandom_range(0, 9) < 7) ? VAL_W'($urandom_range(0, 4)) : VAL_W'($urandom);
			item.ar = ($urandom_range(0, 9) < 7) ? VAL_W'($urandom_range(0, 4)) : VAL_W'($urandom);
			on_grid = int'(item.row) < h && int'(item.col) < w;
			offer_item(item);
			if (item.op != OP_UNUSED && !(item.op == OP_WRITE && !on_grid)) begin
				done++;
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [VAL_W-1:0] got,
			input logic [VAL_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
		end
	endtask

	// Checks one result transaction against the oldest one owed.
	task automatic check_outcome();
		outcome_t want;
		if (due_outcomes.size() == 0) begin
			report_mismatch($sformatf("result of kind %0d with nothing pending", m_tuser));
		end else begin
			want = due_outcomes.pop_front();
			compare_field("result_kind", VAL_W'(m_tuser), VAL_W'(want.kind));
			compare_field("cell_state", VAL_W'(m_tdata[STATE_W-1:0]), VAL_W'(want.state));
			compare_field("cell_health", m_tdata[STATE_W+VAL_W-1:STATE_W], want.health);
			compare_field("cell_armor", m_tdata[STATE_W+2*VAL_W-1:STATE_W+VAL_W], want.armor);
		end
	endtask

	// Receiver: checks each transaction, then chooses the next ready, with one
	// long hold-off on request.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			check_outcome();
		end
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(0, 99) >= 17);
		end
	end

	// Stimulus: reset, directed table, then random phases.
	initial begin
		for (int ri = 0; ri < MAX_ROWS; ri++) begin
			for (int ci = 0; ci < MAX_COLS; ci++) begin
				grid_mem[ri][ci].state  = CELL_GROW;
				grid_mem[ri][ci].health = RESET_HEALTH;
				grid_mem[ri][ci].armor  = RESET_ARMOR;
			end
		end
		cols_cfg  = DIM_RESET;
		rows_cfg  = DIM_RESET;
		regrow_hp = RESET_HEALTH;
		regrow_ar = RESET_ARMOR;

		// Full grid at reset settings: corners, extremes, a small fire, odd codes.
		dir_rows[0]  = known_row(OP_READ, 0, 0, KIND_READ, CELL_GROW, RESET_HEALTH, RESET_ARMOR);
		dir_rows[1]  = known_row(OP_READ, 63, 63, KIND_READ, CELL_GROW, RESET_HEALTH, RESET_ARMOR);
		dir_rows[2]  = plain_row(OP_WRITE, 0, 0, CELL_BURN, 255, 255);
		dir_rows[3]  = plain_row(OP_WRITE, 63, 63, CELL_SPARE, 0, 0);
		dir_rows[4]  = known_row(OP_READ, 63, 63, KIND_READ, CELL_SPARE, 0, 0);
		dir_rows[5]  = plain_row(OP_WRITE, 0, 63, CELL_DEAD, 255, 0);
		dir_rows[6]  = plain_row(OP_WRITE, 63, 0, CELL_GROW, 1, 1);
		dir_rows[7]  = plain_row(OP_WRITE, 62, 1, CELL_BURN, 1, 255);
		dir_rows[8]  = plain_row(OP_WRITE, 1, 1, CELL_GROW, 0, 7);
		dir_rows[9]  = plain_row(OP_UNUSED, 63, 63, CELL_SPARE, 255, 255);
		dir_rows[10] = known_row(OP_STEP, 0, 0, KIND_STEP, CELL_GROW, 0, 0);
		dir_rows[11] = plain_row(OP_READ, 0, 0, CELL_GROW, 0, 0);
		dir_rows[12] = plain_row(OP_READ, 63, 0, CELL_GROW, 0, 0);
		dir_rows[13] = plain_row(OP_READ, 0, 63, CELL_GROW, 0, 0);
		dir_rows[14] = plain_row(OP_READ, 1, 1, CELL_GROW, 0, 0);
		dir_rows[15] = plain_row(OP_READ, 63, 63, CELL_GROW, 0, 0);
		dir_rows[16] = plain_row(OP_READ, 0, 1, CELL_GROW, 0, 0);
		// Five by four grid: accesses just outside it, and a regrowth that burns.
		dir_rows[17] = plain_row(OP_WRITE, 4, 0, CELL_GROW, 1, 1);
		dir_rows[18] = plain_row(OP_WRITE, 0, 5, CELL_BURN, 1, 1);
		dir_rows[19] = known_row(OP_READ, 4, 0, KIND_READ, CELL_GROW, 0, 0);
		dir_rows[20] = known_row(OP_READ, 0, 5, KIND_READ, CELL_GROW, 0, 0);
		dir_rows[21] = plain_row(OP_WRITE, 3, 4, CELL_DEAD, 9, 9);
		dir_rows[22] = known_row(OP_STEP, 0, 0, KIND_STEP, CELL_GROW, 0, 0);
		dir_rows[23] = plain_row(OP_READ, 3, 4, CELL_GROW, 0, 0);
		// Zero width: nothing is in use, yet the step still finishes.
		dir_rows[24] = known_row(OP_STEP, 0, 0, KIND_STEP, CELL_GROW, 0, 0);
		dir_rows[25] = known_row(OP_READ, 0, 0, KIND_READ, CELL_GROW, 0, 0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == DIR_SMALL) begin
				settle();
				program_grid(8'd5, 8'd4, 8'd255, 8'd0);
			end
			if (i == DIR_EMPTY) begin
				settle();
				write_reg(CFG_GRID_WIDTH, 8'd0);
				cfg_we <= 1'b0;
			end
			offer_item(dir_rows[i]);
		end

		// Random phases: oversized dimensions, a single cell, thin strips, then
		// small random grids. The third runs without idling, the fourth opens
		// with a long receiver hold-off.
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: program_grid(8'hFF, 8'hC0, 8'd255, 8'd255);
				1: program_grid(8'd1, 8'd1, 8'd0, 8'd0);
				2: program_grid(8'd64, 8'd2, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
				3: program_grid(8'd2, 8'd64, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
				default: program_grid(CFG_DATA_W'($urandom_range(3, 8)),
					CFG_DATA_W'($urandom_range(3, 8)), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom));
			endcase
			quiet <= (p == 2);
			if (p == 3) begin
				hold_req <= 1'b1;
			end
			run_phase((p == 0) ? 14 : (p == 1) ? 10 : (p < 4) ? 16 : 14, (p == 0) ? 6 : 15);
		end

		settle();
		if (fail_count == 0) begin
			$display("** forest_fire_automaton_step_unit: PASSED **");
		end else begin
			$display("** forest_fire_automaton_step_unit: FAILED **");
		end
		$finish;
	end

endmodule
